### src/sge_pkg.sv
package sge_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic signed [WORD_W-1:0] sword_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // handshake between the sequencer and the remainder unit
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } rem_req_t;

    typedef struct packed {
        logic  done;
        word_t remainder;
    } rem_rsp_t;

    // magnitude of a two's complement word; the most negative value maps to 2^31
    function automatic word_t magnitude(input sword_t value);
        word_t mag;
        mag = word_t'(value);
        if (value[WORD_W-1])
        begin
            mag = ~mag + word_t'(1);
        end
        return mag;
    endfunction

endpackage

### src/sge_in_if.sv
interface sge_in_if;
    import sge_pkg::*;

    logic   valid;
    logic   ready;
    word_t  tag;
    sword_t operand_a;
    sword_t operand_b;

    modport source (output valid, output tag, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input tag, input operand_a, input operand_b,
                    output ready);
endinterface

### src/sge_out_if.sv
interface sge_out_if;
    import sge_pkg::*;

    logic  valid;
    logic  ready;
    word_t result_tag;
    word_t divisor;

    modport source (output valid, output result_tag, output divisor, input ready);
    modport sink   (input valid, input result_tag, input divisor, output ready);
endinterface

### src/sge_rem.sv
module sge_rem (
    input  logic              clk,
    input  logic              rst_n,
    input  sge_pkg::rem_req_t req,
    output sge_pkg::rem_rsp_t rsp
);
    import sge_pkg::*;

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    cnt_t  cnt_reg, cnt_next;
    word_t dvd_reg, dvd_next;
    word_t dsr_reg, dsr_next;
    word_t rem_reg, rem_next;

    logic [WORD_W:0] shifted;
    logic [WORD_W:0] diff;

    // one restoring shift-subtract step per cycle while busy
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[WORD_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            rem_next = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
            cnt_next = cnt_reg + cnt_t'(1);
            if (cnt_reg == cnt_t'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### src/signed_gcd_euclid.sv
// channel   | modport | payload                          | transfer when
// ----------+---------+----------------------------------+--------------------
// in_ch     | sink    | tag, operand_a, operand_b        | valid && ready
// out_ch    | source  | result_tag, divisor              | valid && ready
//
// one task at a time: in_ch.ready is high only while idle
// each task runs k remainder steps (at most 44), all served by the single
// shift-subtract remainder unit
// rst_n clears the sequencer and the remainder unit control; no clearing pass
// the result holds in an output register until out_ch.ready; a stall there
// only delays the next in_ch transfer
module signed_gcd_euclid (
    input  logic      clk,
    input  logic      rst_n,
    sge_in_if.sink    in_ch,
    sge_out_if.source out_ch
);
    import sge_pkg::*;

    state_t state_reg, state_next;

    // working pair of the euclid loop and the tag in flight
    word_t larger_reg, larger_next;
    word_t smaller_reg, smaller_next;
    word_t tag_reg, tag_next;

    word_t    mag_a;
    word_t    mag_b;
    rem_req_t rem_req;
    rem_rsp_t rem_rsp;

    sge_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // magnitudes formed on the transfer cycle
    assign mag_a = magnitude(in_ch.operand_a);
    assign mag_b = magnitude(in_ch.operand_b);

    always_comb
    begin
        state_next       = state_reg;
        larger_next      = larger_reg;
        smaller_next     = smaller_reg;
        tag_next         = tag_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = larger_reg;
        rem_req.divisor  = smaller_reg;
        in_ch.ready      = 1'b0;
        out_ch.valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    tag_next = in_ch.tag;
                    // order as larger and smaller
                    if (mag_a >= mag_b)
                    begin
                        larger_next  = mag_a;
                        smaller_next = mag_b;
                    end
                    else
                    begin
                        larger_next  = mag_b;
                        smaller_next = mag_a;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // a zero smaller value ends the loop; covers gcd(x,0) and gcd(0,0)
                if (smaller_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_req.start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_rsp.done)
                begin
                    larger_next  = smaller_reg;
                    smaller_next = rem_rsp.remainder;
                    state_next   = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        larger_reg  <= larger_next;
        smaller_reg <= smaller_next;
        tag_reg     <= tag_next;
    end

    assign out_ch.result_tag = tag_reg;
    assign out_ch.divisor    = larger_reg;

endmodule

### sim/signed_gcd_euclid_tb.sv
module signed_gcd_euclid_tb;
    import sge_pkg::*;

    // stimulus sizes and receiver hold-off
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 750;
    localparam int HOLD_CYCLES  = 3000;

    // one directed row; known marks a divisor typed in by hand
    typedef struct packed {
        word_t  tag;
        sword_t a;
        sword_t b;
        logic   known;
        word_t  divisor;
    } gcd_case_t;

    // one expected transfer on the result channel
    typedef struct packed {
        word_t tag;
        word_t divisor;
    } gcd_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sge_in_if  in_ch ();
    sge_out_if out_ch ();

    signed_gcd_euclid u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 4 time unit period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gcd_result_t pending_gcds[$];
    int          tasks_sent     = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;

    // directed rows: zero operands, most negative value, equal magnitudes,
    // all-ones and alternating tags, and the longest remainder chain
    // (consecutive fibonacci numbers)
    gcd_case_t directed_cases [NUM_DIRECTED] = '{
        '{32'h0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1'b1, 32'h8000_0000},
        '{32'hAAAA_AAAA, 32'sh0000_0000, 32'sh8000_0000, 1'b1, 32'h8000_0000},
        '{32'h5555_5555, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 32'h8000_0000},
        '{32'h0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{32'h8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{32'h7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'h0000_0002, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'h0000_0003, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'h0000_0004, 32'sh0000_0001, 32'sh8000_0000, 1'b1, 32'h0000_0001},
        '{32'h1234_5678, 32'sd1134903170, 32'sd1836311903, 1'b0, 32'h0000_0000},
        '{32'h8765_4321, -32'sd1836311903, 32'sd1134903170, 1'b0, 32'h0000_0000},
        '{32'h0000_0010, 32'sd48, -32'sd18, 1'b0, 32'h0000_0000},
        '{32'h0000_0011, 32'sh8000_0000, -32'sd65536, 1'b0, 32'h0000_0000},
        '{32'h0000_0012, 32'sh5555_5555, 32'sh2AAA_AAAA, 1'b0, 32'h0000_0000},
        '{32'h0000_0013, 32'sd12, 32'sd12, 1'b0, 32'h0000_0000},
        '{32'h0000_0014, 32'sd7, -32'sd7, 1'b1, 32'h0000_0007},
        '{32'h0000_0015, 32'sd360, 32'sd0, 1'b1, 32'h0000_0168},
        '{32'h0000_0016, 32'sh4000_0000, 32'shC000_0000, 1'b1, 32'h4000_0000},
        '{32'hDEAD_BEEF, 32'sd1000000007, 32'sd998244353, 1'b0, 32'h0000_0000}
    };

    // gcd of the two operand magnitudes, remainder form of euclid
    function automatic word_t gcd_of_magnitudes(input sword_t a, input sword_t b);
        word_t mag_a;
        word_t mag_b;
        word_t big;
        word_t rest;
        word_t rem;
        // negating the most negative value wraps to 2^31, which is its magnitude
        mag_a = a[WORD_W-1] ? word_t'(-a) : word_t'(a);
        mag_b = b[WORD_W-1] ? word_t'(-b) : word_t'(b);
        big   = (mag_a >= mag_b) ? mag_a : mag_b;
        rest  = (mag_a >= mag_b) ? mag_b : mag_a;
        while (rest != '0)
        begin
            rem  = big % rest;
            big  = rest;
            rest = rem;
        end
        return big;
    endfunction

    function automatic sword_t with_sign(input sword_t value);
        return ($urandom_range(0, 1) == 1) ? -value : value;
    endfunction

    // random operand pairs: plain words, shared factors, short words,
    // multiples, corner values and equal magnitudes
    function automatic void pick_operands(output sword_t a, output sword_t b);
        word_t  factor;
        sword_t swap;
        case ($urandom_range(0, 9)) inside
            [0:3]:
            begin
                a = $urandom;
                b = $urandom;
            end
            [4:5]:
            begin
                // product stays below 2^31
                factor = $urandom_range(1, 65535);
                a = with_sign(factor * $urandom_range(0, 32767));
                b = with_sign(factor * $urandom_range(0, 32767));
            end
            6:
            begin
                a = with_sign($urandom >> $urandom_range(0, 31));
                b = with_sign($urandom >> $urandom_range(0, 31));
            end
            7:
            begin
                a = with_sign($urandom_range(1, 65535));
                b = with_sign(a * $urandom_range(0, 32767));
            end
            8:
            begin
                case ($urandom_range(0, 4))
                    0:       a = 32'sh0000_0000;
                    1:       a = 32'sh8000_0000;
                    2:       a = 32'sh0000_0001;
                    3:       a = 32'shFFFF_FFFF;
                    default: a = 32'sh7FFF_FFFF;
                endcase
                b = $urandom;
            end
            default:
            begin
                a = $urandom;
                b = with_sign(a);
            end
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            swap = a;
            a    = b;
            b    = swap;
        end
    endfunction

    task automatic report_mismatch(input string what, input word_t tag, input word_t got,
                                   input word_t want);
        $display("mismatch at %0t: %s, tag %h, got %h, want %h", $time, what, tag,
                 got, want);
        mismatch_count++;
    endtask

    // offer one task, wait for its transfer, queue its expected divisor,
    // then maybe leave the channel idle for a while
    task automatic send_task(input word_t tag, input sword_t a, input sword_t b,
                             input logic known, input word_t want, input logic may_idle);
        gcd_result_t expected;
        int          gap;
        in_ch.valid     <= 1'b1;
        in_ch.tag       <= tag;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        // ready read right after the edge is the value the block sampled there
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected.tag     = tag;
        expected.divisor = known ? want : gcd_of_magnitudes(a, b);
        pending_gcds.push_back(expected);
        tasks_sent++;
        if (may_idle && $urandom_range(0, 99) < 30)
        begin
            // mostly short gaps, some long enough to leave the block idle
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 1500)
                                              : $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender: reset, directed table, random tasks, drain, verdict
    initial
    begin
        gcd_case_t row;
        sword_t    a;
        sword_t    b;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.tag       <= '0;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            row = directed_cases[i];
            send_task(row.tag, row.a, row.b, row.known, row.divisor, 1'b1);
        end

        // tasks 350 to 449 go back to back with no gaps
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            pick_operands(a, b);
            send_task($urandom, a, b, 1'b0, '0, !(n >= 350 && n < 450));
        end
        in_ch.valid <= 1'b0;

        // drain, then a short quiet spell to catch stray transfers
        while (pending_gcds.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off while the sender keeps
    // offering, and a stretch of results taken without any stall
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && tasks_sent >= 120)
            begin
                // result register fills and the input stalls behind it
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else if (results_seen >= 350 && results_seen < 450)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // compare each result transfer with the oldest outstanding task
    always @(posedge clk)
    begin
        gcd_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_gcds.size() == 0)
            begin
                report_mismatch("result with no task outstanding", out_ch.result_tag,
                                out_ch.divisor, '0);
            end
            else
            begin
                want = pending_gcds.pop_front();
                if (out_ch.result_tag !== want.tag)
                begin
                    report_mismatch("result_tag", want.tag, out_ch.result_tag, want.tag);
                end
                if (out_ch.divisor !== want.divisor)
                begin
                    report_mismatch("divisor", want.tag, out_ch.divisor, want.divisor);
                end
            end
        end
    end

    // hang guard, well beyond the slowest legal run
    initial
    begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
src/sge_pkg.sv
src/sge_in_if.sv
src/sge_out_if.sv
src/sge_rem.sv
src/signed_gcd_euclid.sv
sim/signed_gcd_euclid_tb.sv
